### sv/ccs_pkg.sv
package ccs_pkg;

   localparam int WORD_W  = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int CSR_W   = 64;
   localparam int CSR_IDX_W = 3;

   typedef struct packed {
      logic [WORD_W-1:0] data_word;
      logic [2:0]        byte_count;
      logic              last_word;
   } entry_type;

   typedef struct packed {
      logic [3:0][63:0]  key;
      logic [63:0]       nonce_lo;
      logic [31:0]       nonce_hi;
      logic [31:0]       start_counter;
      logic [3:0]        double_rounds;
   } cfg_type;

   typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] block_type;

   // "expand 32-byte k", word 0 in the low slot
   localparam logic [3:0][WORD_W-1:0] SIGMA = {
      32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
   };

   localparam logic [CSR_IDX_W-1:0] CSR_KEY0     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY1     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY2     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY3     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_LO = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_HI = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_START    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUNDS   = 3'd7;

   localparam logic [3:0] ROUNDS_RESET = 4'd10;
   localparam logic [2:0] FULL_BYTES   = 3'd4;

endpackage

### sv/ccs_chan_if.sv
interface ccs_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  byte_count;
   logic        last_word;

   modport source (output valid, data_word, byte_count, last_word, input ready);
   modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface ccs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_word;
   logic [2:0]  result_bytes;
   logic        result_last;

   modport source (output valid, result_word, result_bytes, result_last, input ready);
   modport sink   (input valid, result_word, result_bytes, result_last, output ready);
endinterface

### sv/ccs_front.sv
module ccs_front #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   ccs_req_if.sink            req_chan,
   output ccs_pkg::entry_type head,
   output logic               head_valid,
   input  logic               pop
);
   import ccs_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        q_ff [DEPTH];
   entry_type        entry;
   logic [IDX_W-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push;

   assign req_chan.ready = (cnt_ff != CNT_W'(DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign head_valid     = (cnt_ff != '0);
   assign head           = q_ff[rd_ff];

   // zero or above four counts as a full word
   always_comb begin
      entry.data_word = req_chan.data_word;
      entry.last_word = req_chan.last_word;
      if (req_chan.byte_count == 3'd0 || req_chan.byte_count > FULL_BYTES) begin
         entry.byte_count = FULL_BYTES;
      end else begin
         entry.byte_count = req_chan.byte_count;
      end
   end

   always_comb begin
      rd_in  = rd_ff;
      wr_in  = wr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= entry;
      end
   end

endmodule

### sv/ccs_core.sv
module ccs_core (
   input  logic               clock,
   input  logic               reset,
   input  ccs_pkg::cfg_type   cfg,
   input  logic [31:0]        block_count,
   input  logic               start,
   output logic               done,
   output ccs_pkg::block_type keystream
);
   import ccs_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [1:0]        step_ff, step_in;
   logic              diag_ff, diag_in;
   logic [3:0]        round_ff, round_in;
   logic [WORD_W-1:0] x_ff [BLOCK_WORDS];
   logic [WORD_W-1:0] x_in [BLOCK_WORDS];
   logic [WORD_W-1:0] x_step [BLOCK_WORDS];
   logic [WORD_W-1:0] init [BLOCK_WORDS];
   logic [WORD_W-1:0] la [4];
   logic [WORD_W-1:0] lb [4];
   logic [WORD_W-1:0] lc [4];
   logic [WORD_W-1:0] ld [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         init[i]         = SIGMA[i];
         init[4 + 2 * i] = cfg.key[i][31:0];
         init[5 + 2 * i] = cfg.key[i][63:32];
      end
      init[12] = block_count;
      init[13] = cfg.nonce_lo[31:0];
      init[14] = cfg.nonce_lo[63:32];
      init[15] = cfg.nonce_hi;
   end

   // four quarter-round lanes, one add-xor-rotate step each per cycle
   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [WORD_W-1:0] a, b, c, d, sum_ab, sum_cd, xab, xcd;

      assign a = x_ff[l];
      assign b = diag_ff ? x_ff[4 + ((l + 1) % 4)]  : x_ff[4 + l];
      assign c = diag_ff ? x_ff[8 + ((l + 2) % 4)]  : x_ff[8 + l];
      assign d = diag_ff ? x_ff[12 + ((l + 3) % 4)] : x_ff[12 + l];
      assign sum_ab = a + b;
      assign sum_cd = c + d;
      assign xab    = d ^ sum_ab;
      assign xcd    = b ^ sum_cd;

      always_comb begin
         la[l] = a;
         lb[l] = b;
         lc[l] = c;
         ld[l] = d;
         case (step_ff)
            2'd0: begin
               la[l] = sum_ab;
               ld[l] = {xab[15:0], xab[31:16]};
            end
            2'd1: begin
               lc[l] = sum_cd;
               lb[l] = {xcd[19:0], xcd[31:20]};
            end
            2'd2: begin
               la[l] = sum_ab;
               ld[l] = {xab[23:0], xab[31:24]};
            end
            default: begin
               lc[l] = sum_cd;
               lb[l] = {xcd[24:0], xcd[31:25]};
            end
         endcase
      end
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         x_step[j]      = la[j];
         x_step[4 + j]  = diag_ff ? lb[(j + 3) % 4] : lb[j];
         x_step[8 + j]  = diag_ff ? lc[(j + 2) % 4] : lc[j];
         x_step[12 + j] = diag_ff ? ld[(j + 1) % 4] : ld[j];
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      diag_in  = diag_ff;
      round_in = round_ff;
      x_in     = x_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in     = init;
               step_in  = '0;
               diag_in  = 1'b0;
               round_in = '0;
               state_in = (cfg.double_rounds == '0) ? ST_FINAL : ST_ROUND;
            end
         end
         ST_ROUND: begin
            x_in    = x_step;
            step_in = step_ff + 1'b1;
            if (step_ff == 2'd3) begin
               diag_in = !diag_ff;
               if (diag_ff) begin
                  round_in = round_ff + 1'b1;
                  if (4'(round_ff + 1'b1) == cfg.double_rounds) begin
                     state_in = ST_FINAL;
                  end
               end
            end
         end
         ST_FINAL: begin
            for (int i = 0; i < BLOCK_WORDS; i++) begin
               x_in[i] = x_ff[i] + init[i];
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         diag_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         diag_ff  <= diag_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
   end

   assign done = (state_ff == ST_FINAL);

   always_comb begin
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         keystream[i] = x_ff[i];
      end
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE)
      else $error("block start while round core busy");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> round_ff < cfg.double_rounds)
      else $error("double-round counter overran");

endmodule

### sv/ccs_back.sv
module ccs_back (
   input  logic               clock,
   input  logic               reset,
   input  ccs_pkg::cfg_type   cfg,
   input  logic               load_counter,
   input  logic [31:0]        load_value,
   input  ccs_pkg::entry_type head,
   input  logic               head_valid,
   output logic               pop,
   output logic               core_start,
   output logic [31:0]        block_count,
   input  logic               core_done,
   input  ccs_pkg::block_type keystream,
   ccs_rsp_if.source          rsp_chan
);
   import ccs_pkg::*;

   logic [3:0]        pos_ff, pos_in, pos_next;
   logic              ready_ff, ready_in;
   logic              building_ff, building_in;
   logic [31:0]       bc_ff, bc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] word_ff;
   logic [2:0]        bytes_ff;
   logic              last_ff;
   logic [WORD_W-1:0] mask;

   assign pop        = head_valid && ready_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign core_start = head_valid && !ready_ff && !building_ff;
   assign block_count = bc_ff;
   assign pos_next   = pos_ff + 1'b1;

   always_comb begin
      case (head.byte_count)
         3'd1:    mask = 32'h0000_00ff;
         3'd2:    mask = 32'h0000_ffff;
         3'd3:    mask = 32'h00ff_ffff;
         default: mask = 32'hffff_ffff;
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      ready_in     = ready_ff;
      building_in  = building_ff;
      bc_in        = bc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (core_start) begin
         building_in = 1'b1;
      end
      if (core_done) begin
         building_in = 1'b0;
         ready_in    = 1'b1;
      end
      if (pop) begin
         rsp_valid_in = 1'b1;
         pos_in       = pos_next;
         if (pos_next == '0) begin
            bc_in    = bc_ff + 1'b1;
            ready_in = 1'b0;
         end
         if (head.last_word) begin
            bc_in    = cfg.start_counter;
            pos_in   = '0;
            ready_in = 1'b0;
         end
      end
      if (load_counter) begin
         bc_in = load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         ready_ff     <= 1'b0;
         building_ff  <= 1'b0;
         bc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         ready_ff     <= ready_in;
         building_ff  <= building_in;
         bc_ff        <= bc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         word_ff  <= (head.data_word ^ keystream[pos_ff]) & mask;
         bytes_ff <= head.byte_count;
         last_ff  <= head.last_word;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_word  = word_ff;
   assign rsp_chan.result_bytes = bytes_ff;
   assign rsp_chan.result_last  = last_ff;

   a_no_pop_while_building: assert property (@(posedge clock) disable iff (reset)
      building_ff |-> !pop && !ready_ff)
      else $error("transfer taken while keystream block under construction");

   a_last_rewinds: assert property (@(posedge clock) disable iff (reset)
      pop && head.last_word && !load_counter |=> pos_ff == '0 && !ready_ff)
      else $error("message end did not rewind keystream position");

   a_done_sets_ready: assert property (@(posedge clock) disable iff (reset)
      core_done |=> ready_ff && !building_ff)
      else $error("finished block not marked ready");

endmodule

### sv/chacha_stream_cipher.sv
// ChaCha stream cipher (32-bit block counter, 96-bit nonce), one 32-bit
// little-endian word per transfer; encryption and decryption are the same.
// Words are queued on entry and XORed with the current keystream block. A new
// block is generated when the first word of each 64-byte block is at the head
// of the queue: the state is loaded, the double rounds run (a single
// add-xor-rotate step across four quarter-round lanes per cycle), the final
// addition is made, and each word's result is registered. The block's words
// (up to 16) then go out at one per cycle while words are queued and the
// result side is ready. The message ends on last_word: the counter reloads
// start_counter and the next word starts a fresh block. Writing start_counter
// also reloads the running block counter. Configure only while no words are in flight.
module chacha_stream_cipher #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   ccs_req_if.sink     req_chan,
   ccs_rsp_if.source   rsp_chan,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import ccs_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   entry_type   head;
   logic        head_valid;
   logic        pop;
   logic        core_start;
   logic        core_done;
   logic        load_counter;
   logic [31:0] block_count;
   block_type   keystream;

   assign load_counter = csr_wen && (csr_index == CSR_START);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_KEY0:     cfg_in.key[0]        = csr_wdata;
            CSR_KEY1:     cfg_in.key[1]        = csr_wdata;
            CSR_KEY2:     cfg_in.key[2]        = csr_wdata;
            CSR_KEY3:     cfg_in.key[3]        = csr_wdata;
            CSR_NONCE_LO: cfg_in.nonce_lo      = csr_wdata;
            CSR_NONCE_HI: cfg_in.nonce_hi      = csr_wdata[31:0];
            CSR_START:    cfg_in.start_counter = csr_wdata[31:0];
            CSR_ROUNDS:   cfg_in.double_rounds = csr_wdata[3:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{key: '0, nonce_lo: '0, nonce_hi: '0, start_counter: '0,
                     double_rounds: ROUNDS_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ccs_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop)
   );

   ccs_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .block_count (block_count),
      .start       (core_start),
      .done        (core_done),
      .keystream   (keystream)
   );

   ccs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .load_counter (load_counter),
      .load_value   (csr_wdata[31:0]),
      .head         (head),
      .head_valid   (head_valid),
      .pop          (pop),
      .core_start   (core_start),
      .block_count  (block_count),
      .core_done    (core_done),
      .keystream    (keystream),
      .rsp_chan     (rsp_chan)
   );

endmodule

### test/chacha_stream_cipher_tb.sv
`timescale 1ns / 1ps

module chacha_stream_cipher_tb;
   import ccs_pkg::*;

   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int SINK_HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES      = 160;   // margin for the slowest block, at 15 double rounds
   localparam int PHASES           = 8;
   localparam int PHASE_WORDS      = 80;

   typedef struct packed {
      logic [WORD_W-1:0] text;
      logic [2:0]        nbytes;
      logic              last;
   } cipher_word_type;

   class keystream_checker;
      cfg_type         regs;
      bit [31:0]       ks[16];
      bit [31:0]       mix[16];
      bit [31:0]       blk_ctr;
      bit [3:0]        word_pos;
      bit              ks_valid;
      cipher_word_type expected[$];
      int              mismatches;
      int              checked;

      function new();
         regs = '0;
         regs.double_rounds = ROUNDS_RESET;
         blk_ctr = '0;
         word_pos = '0;
         ks_valid = 1'b0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_KEY0:     regs.key[0] = val;
            CSR_KEY1:     regs.key[1] = val;
            CSR_KEY2:     regs.key[2] = val;
            CSR_KEY3:     regs.key[3] = val;
            CSR_NONCE_LO: regs.nonce_lo = val;
            CSR_NONCE_HI: regs.nonce_hi = val[31:0];
            CSR_START: begin
               regs.start_counter = val[31:0];
               blk_ctr = val[31:0];
            end
            CSR_ROUNDS:   regs.double_rounds = val[3:0];
            default: ;
         endcase
      endfunction

      function bit [31:0] rotl(bit [31:0] v, int n);
         return (v << n) | (v >> (32 - n));
      endfunction

      function void quarter(int a, int b, int c, int d);
         mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
         mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
         mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
         mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
      endfunction

      function void build_block();
         bit [31:0] seed[16];
         for (int i = 0; i < 4; i++) begin
            seed[i] = SIGMA[i];
            seed[4 + 2 * i] = regs.key[i][31:0];
            seed[5 + 2 * i] = regs.key[i][63:32];
         end
         seed[12] = blk_ctr;
         seed[13] = regs.nonce_lo[31:0];
         seed[14] = regs.nonce_lo[63:32];
         seed[15] = regs.nonce_hi;
         mix = seed;
         for (int r = 0; r < regs.double_rounds; r++) begin
            quarter(0, 4, 8, 12);
            quarter(1, 5, 9, 13);
            quarter(2, 6, 10, 14);
            quarter(3, 7, 11, 15);
            quarter(0, 5, 10, 15);
            quarter(1, 6, 11, 12);
            quarter(2, 7, 8, 13);
            quarter(3, 4, 9, 14);
         end
         for (int i = 0; i < 16; i++) ks[i] = mix[i] + seed[i];
      endfunction

      function void note_word(entry_type item);
         cipher_word_type want;
         bit [2:0]        n;
         bit [31:0]       mask;
         n = item.byte_count;
         if (n == 3'd0 || n > FULL_BYTES) n = FULL_BYTES;
         mask = (n == FULL_BYTES) ? 32'hffff_ffff : (32'h1 << (8 * n)) - 32'h1;
         if (!ks_valid) begin
            build_block();
            ks_valid = 1'b1;
         end
         want.text = (item.data_word ^ ks[word_pos]) & mask;
         want.nbytes = n;
         want.last = item.last_word;
         word_pos++;
         if (word_pos == 4'd0) begin
            blk_ctr++;
            ks_valid = 1'b0;
         end
         if (item.last_word) begin
            blk_ctr = regs.start_counter;
            word_pos = '0;
            ks_valid = 1'b0;
         end
         expected.push_back(want);
      endfunction

      function void check_word(logic [31:0] text, logic [2:0] nbytes, logic last);
         cipher_word_type want;
         checked++;
         if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result %h bytes %0d last %b", $time, text, nbytes, last);
         end else begin
            want = expected.pop_front();
            if (text !== want.text || nbytes !== want.nbytes || last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result %0d mismatch: word %h/%h bytes %0d/%0d last %b/%b (exp/act)",
                           $time, checked, want.text, text, want.nbytes, nbytes, want.last, last);
            end
         end
      endfunction

      function int pending();
         return expected.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_wen;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   ccs_req_if req_bus();
   ccs_rsp_if rsp_bus();

   keystream_checker cipher_model;
   bit sender_gaps;
   bit sink_gaps;
   bit idle_phase;
   bit sink_hold_req;
   int words_sent;
   int messages;
   int settings;
   int cycles;

   chacha_stream_cipher i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles, cipher_model.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         cipher_model.check_word(rsp_bus.result_word, rsp_bus.result_bytes, rsp_bus.result_last);
   end

   // result side: long hold-off on request, random stalls, or stretches of ready
   initial begin
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (SINK_HOLD_CYCLES) @(posedge clock);
         end else if (sink_gaps && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      cipher_model.write_reg(idx, val);
   endtask

   task automatic program_cipher(input logic [3:0][63:0] key, input logic [63:0] nonce_lo,
                                 input logic [31:0] nonce_hi, input logic [31:0] ctr,
                                 input logic [3:0] rounds);
      csr_write(CSR_KEY0, key[0]);
      csr_write(CSR_KEY1, key[1]);
      csr_write(CSR_KEY2, key[2]);
      csr_write(CSR_KEY3, key[3]);
      csr_write(CSR_NONCE_LO, nonce_lo);
      csr_write(CSR_NONCE_HI, {32'h0, nonce_hi});
      csr_write(CSR_START, {32'h0, ctr});
      csr_write(CSR_ROUNDS, {60'h0, rounds});
      settings++;
   endtask

   // called at the edge of the last transfer
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (cipher_model.pending() != 0) @(posedge clock);
   endtask

   task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes, input logic last);
      entry_type item;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      item.data_word = data;
      item.byte_count = nbytes;
      item.last_word = last;
      req_bus.valid      <= 1'b1;
      req_bus.data_word  <= data;
      req_bus.byte_count <= nbytes;
      req_bus.last_word  <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      cipher_model.note_word(item);
      words_sent++;
      if (last) messages++;
   endtask

   task automatic run_phase(input int n_words);
      int          left;
      int          len;
      logic [31:0] data;
      logic [2:0]  nbytes;
      logic        last;
      left = n_words;
      while (left > 0) begin
         case ($urandom_range(0, 7))
            0:       len = 16;
            1:       len = 32;
            2:       len = $urandom_range(1, 3);
            3:       len = $urandom_range(15, 17);
            default: len = $urandom_range(1, 40);
         endcase
         if (len > left) len = left;
         sender_gaps = idle_phase && ($urandom_range(0, 2) != 0);
         for (int k = 0; k < len; k++) begin
            // settings change in the middle of a message, with nothing in flight
            if (k == len / 2 && len >= 4 && $urandom_range(0, 7) == 0) begin
               drain();
               csr_write(CSR_START, {32'h0, $urandom});
               csr_write(CSR_KEY0 + 3'($urandom_range(0, 3)), {$urandom, $urandom});
            end
            case ($urandom_range(0, 15))
               0:       data = 32'h0000_0000;
               1:       data = 32'hffff_ffff;
               default: data = $urandom;
            endcase
            last = (k == len - 1);
            if (last)
               nbytes = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(1, 4));
            else
               nbytes = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : FULL_BYTES;
            send_word(data, nbytes, last);
         end
         left -= len;
      end
   endtask

   initial begin
      logic [3:0] rounds;
      logic [31:0] ctr;
      int failures;
      cipher_model = new();
      req_bus.valid      <= 1'b0;
      req_bus.data_word  <= '0;
      req_bus.byte_count <= FULL_BYTES;
      req_bus.last_word  <= 1'b0;
      csr_wen   <= 1'b0;
      csr_index <= CSR_KEY0;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_phase = 1'b1;
      sender_gaps = 1'b1;
      sink_gaps = 1'b1;

      // settings straight out of reset
      send_word(32'h0000_0000, FULL_BYTES, 1'b0);
      send_word(32'hffff_ffff, FULL_BYTES, 1'b1);
      drain();

      // everything at its top value, short and out-of-range byte counts
      program_cipher('1, '1, 32'hffff_ffff, 32'hffff_ffff, 4'd15);
      send_word(32'h0123_4567, 3'd1, 1'b0);
      send_word(32'h89ab_cdef, 3'd2, 1'b0);
      send_word(32'hffff_ffff, 3'd3, 1'b0);
      send_word(32'h0000_0000, 3'd0, 1'b0);
      send_word(32'hdead_beef, 3'd5, 1'b0);
      send_word(32'h5555_5555, 3'd6, 1'b0);
      send_word(32'haaaa_aaaa, 3'd7, 1'b0);
      send_word(32'hffff_ffff, 3'd1, 1'b1);
      send_word(32'h1234_5678, 3'd2, 1'b1);
      send_word(32'h8765_4321, 3'd3, 1'b1);
      send_word(32'h0f0f_0f0f, 3'd0, 1'b1);
      drain();

      // no rounds at all
      csr_write(CSR_ROUNDS, 64'd0);
      send_word(32'ha5a5_a5a5, FULL_BYTES, 1'b0);
      send_word(32'h5a5a_5a5a, 3'd3, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         idle_phase = (p < PHASES - 2);
         sink_gaps = idle_phase;
         ctr = ($urandom_range(0, 1) == 0) ? 32'hffff_fff0 + 32'($urandom_range(0, 15))
                                           : 32'($urandom);
         case (p)
            0: program_cipher('0, '0, '0, '0, 4'd1);
            1: program_cipher('1, '1, 32'hffff_ffff, 32'hffff_ffff, 4'd15);
            default: begin
               case (p)
                  2:       rounds = 4'd4;
                  3:       rounds = 4'd6;
                  4:       rounds = 4'($urandom_range(0, 15));
                  7:       rounds = 4'($urandom_range(1, 10));
                  default: rounds = 4'd10;
               endcase
               program_cipher({$urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom},
                              {$urandom, $urandom}, $urandom, ctr, rounds);
            end
         endcase
         if (p == 2) sink_hold_req = 1'b1;
         run_phase(PHASE_WORDS);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      failures = cipher_model.mismatches + cipher_model.pending();
      $display("%0d words in %0d messages over %0d cipher settings, %0d results checked,",
               words_sent, messages, settings, cipher_model.checked);
      $display("rounds 0 to 15, counter wrap, short and mid-message settings changes; %0d errors",
               failures);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
